// File: hw/rtl/lobbp_pkg.sv
// ----------------------------------------------------------------------------
// lobbp_pkg: shared types and constants for the best-price order book
// Scan token layout, slot write command, status codes and side bytes.
// ----------------------------------------------------------------------------
package lobbp_pkg;

    // Operation selector carried on s_tuser
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_CANCEL = 1'b1;

    // ASCII side bytes
    localparam logic [7:0] SIDE_BID = 8'd66;
    localparam logic [7:0] SIDE_ASK = 8'd83;

    // Result status codes
    localparam logic [2:0] ST_ADDED        = 3'd0;
    localparam logic [2:0] ST_CANCELLED    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_SIDE_IGNORED = 3'd3;
    localparam logic [2:0] ST_FULL         = 3'd4;

    // Token that walks the cell row; slot indexes travel beside it
    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic        bid_hit;     // matching bid found so far
        logic [31:0] bid_price;
        logic [31:0] bid_age;
        logic        ask_hit;     // matching ask found so far
        logic [31:0] ask_price;
        logic [31:0] ask_age;
        logic        free_hit;    // free slot found so far
        logic        bid_have;    // at least one resting bid
        logic [31:0] best_bid;
        logic        ask_have;    // at least one resting ask
        logic [31:0] best_ask;
    } lobbp_tok_t;

    // Slot write command, index travels beside it
    typedef struct packed {
        logic        set;
        logic        clr;
        logic        is_ask;
        logic [31:0] price;
        logic [31:0] id;
        logic [31:0] stamp;
    } lobbp_wr_t;

endpackage

// File: hw/rtl/lobbp_cell.sv
// ----------------------------------------------------------------------------
// lobbp_cell: one order slot of the book
// Holds one resting order and updates the passing scan token: first free
// slot, best cancel candidate per side, and best bid / best ask.
// ----------------------------------------------------------------------------
module lobbp_cell
    import lobbp_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lobbp_tok_t       tok_in,
    input  logic [IDX_W-1:0] bid_idx_in,
    input  logic [IDX_W-1:0] ask_idx_in,
    input  logic [IDX_W-1:0] free_idx_in,
    input  lobbp_wr_t        wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      arrival,
    output lobbp_tok_t       tok_out,
    output logic [IDX_W-1:0] bid_idx_out,
    output logic [IDX_W-1:0] ask_idx_out,
    output logic [IDX_W-1:0] free_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        valid_reg;
    logic        is_ask_reg;
    logic [31:0] price_reg;
    logic [31:0] id_reg;
    logic [31:0] stamp_reg;

    lobbp_tok_t       tok_reg, tok_next;
    logic [IDX_W-1:0] bid_idx_reg, bid_idx_next;
    logic [IDX_W-1:0] ask_idx_reg, ask_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic        sel;
    logic        id_eq;
    logic [31:0] age;

    assign sel   = (wr_idx == MY_IDX);
    assign id_eq = (id_reg == tok_in.id);
    assign age   = arrival - stamp_reg;

    // Slot storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sel && wr.set) begin
            valid_reg <= 1'b1;
        end else if (sel && wr.clr) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel && wr.set) begin
            is_ask_reg <= wr.is_ask;
            price_reg  <= wr.price;
            id_reg     <= wr.id;
            stamp_reg  <= wr.stamp;
        end
    end

    // Token update against this slot
    always_comb begin
        tok_next      = tok_in;
        bid_idx_next  = bid_idx_in;
        ask_idx_next  = ask_idx_in;
        free_idx_next = free_idx_in;

        if (!valid_reg && !tok_in.free_hit) begin
            tok_next.free_hit = 1'b1;
            free_idx_next     = MY_IDX;
        end

        // cancel candidate: lowest price, then oldest
        if (valid_reg && !is_ask_reg && id_eq) begin
            if (!tok_in.bid_hit || price_reg < tok_in.bid_price ||
                (price_reg == tok_in.bid_price && age > tok_in.bid_age)) begin
                tok_next.bid_hit   = 1'b1;
                tok_next.bid_price = price_reg;
                tok_next.bid_age   = age;
                bid_idx_next       = MY_IDX;
            end
        end
        if (valid_reg && is_ask_reg && id_eq) begin
            if (!tok_in.ask_hit || price_reg < tok_in.ask_price ||
                (price_reg == tok_in.ask_price && age > tok_in.ask_age)) begin
                tok_next.ask_hit   = 1'b1;
                tok_next.ask_price = price_reg;
                tok_next.ask_age   = age;
                ask_idx_next       = MY_IDX;
            end
        end

        // top of book
        if (valid_reg && !is_ask_reg) begin
            if (!tok_in.bid_have || price_reg > tok_in.best_bid) begin
                tok_next.best_bid = price_reg;
            end
            tok_next.bid_have = 1'b1;
        end
        if (valid_reg && is_ask_reg) begin
            if (!tok_in.ask_have || price_reg < tok_in.best_ask) begin
                tok_next.best_ask = price_reg;
            end
            tok_next.ask_have = 1'b1;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg      <= tok_next;
            bid_idx_reg  <= bid_idx_next;
            ask_idx_reg  <= ask_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign tok_out      = tok_reg;
    assign bid_idx_out  = bid_idx_reg;
    assign ask_idx_out  = ask_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

// File: hw/rtl/lobbp_ctrl.sv
// ----------------------------------------------------------------------------
// lobbp_ctrl: sequencer of the order book
// Accepts one order message, runs a search scan (not for an add with an unknown
// side), commits the slot change, runs a top-of-book scan and presents the result.
// ----------------------------------------------------------------------------
module lobbp_ctrl
    import lobbp_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [71:0]      s_tdata,   // order_id[31:0], side[39:32], price[71:40]
    input  logic [0:0]       s_tuser,   // func[0]
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // best_bid[31:0], bid_present[32],
                                        // best_ask[64:33], ask_present[65], zero pad
    output logic [2:0]       m_tuser,   // status[2:0]
    // cell row
    output lobbp_tok_t       launch,
    input  lobbp_tok_t       tok_last,
    input  logic [IDX_W-1:0] bid_idx_last,
    input  logic [IDX_W-1:0] ask_idx_last,
    input  logic [IDX_W-1:0] free_idx_last,
    output lobbp_wr_t        wr,
    output logic [IDX_W-1:0] wr_idx,
    output logic [31:0]      arrival
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN1 = 2'd1;
    localparam logic [1:0] S_SCAN2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    lobbp_tok_t  launch_reg, launch_next;
    logic        func_reg, func_next;
    logic        is_ask_reg, is_ask_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] id_reg, id_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] ctr_reg, ctr_next;
    logic [31:0] hold_bid_reg, hold_bid_next;
    logic [31:0] hold_ask_reg, hold_ask_next;
    logic        hold_bpres_reg, hold_bpres_next;
    logic        hold_apres_reg, hold_apres_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [31:0] m_bid_reg, m_bid_next;
    logic [31:0] m_ask_reg, m_ask_next;
    logic        m_bpres_reg, m_bpres_next;
    logic        m_apres_reg, m_apres_next;

    logic [31:0] in_id;
    logic [7:0]  in_side;
    logic [31:0] in_price;

    assign in_id    = s_tdata[31:0];
    assign in_side  = s_tdata[39:32];
    assign in_price = s_tdata[71:40];

    assign s_tready = (state_reg == S_IDLE);

    // Sequencer and commit logic
    always_comb begin
        state_next        = state_reg;
        launch_next       = launch_reg;
        launch_next.valid = 1'b0;
        func_next         = func_reg;
        is_ask_next       = is_ask_reg;
        price_next        = price_reg;
        id_next           = id_reg;
        status_next       = status_reg;
        ctr_next          = ctr_reg;
        hold_bid_next     = hold_bid_reg;
        hold_ask_next     = hold_ask_reg;
        hold_bpres_next   = hold_bpres_reg;
        hold_apres_next   = hold_apres_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_status_next     = m_status_reg;
        m_bid_next        = m_bid_reg;
        m_ask_next        = m_ask_reg;
        m_bpres_next      = m_bpres_reg;
        m_apres_next      = m_apres_reg;
        wr                = '0;
        wr_idx            = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next         = s_tuser[0];
                    is_ask_next       = (in_side == SIDE_ASK);
                    price_next        = in_price;
                    id_next           = in_id;
                    launch_next       = '0;
                    launch_next.valid = 1'b1;
                    launch_next.id    = in_id;
                    if (s_tuser[0] == FUNC_ADD && in_side != SIDE_BID &&
                        in_side != SIDE_ASK) begin
                        status_next = ST_SIDE_IGNORED;
                        state_next  = S_SCAN2;
                    end else begin
                        state_next  = S_SCAN1;
                    end
                end
            end
            S_SCAN1: begin
                if (tok_last.valid) begin
                    if (func_reg == FUNC_ADD) begin
                        if (tok_last.free_hit) begin
                            wr.set      = 1'b1;
                            wr.is_ask   = is_ask_reg;
                            wr.price    = price_reg;
                            wr.id       = id_reg;
                            wr.stamp    = ctr_reg;
                            wr_idx      = free_idx_last;
                            ctr_next    = ctr_reg + 32'd1;
                            status_next = ST_ADDED;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end else if (tok_last.bid_hit) begin
                        wr.clr      = 1'b1;
                        wr_idx      = bid_idx_last;
                        status_next = ST_CANCELLED;
                    end else if (tok_last.ask_hit) begin
                        wr.clr      = 1'b1;
                        wr_idx      = ask_idx_last;
                        status_next = ST_CANCELLED;
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                    // second pass sees the updated slots
                    launch_next       = '0;
                    launch_next.valid = 1'b1;
                    state_next        = S_SCAN2;
                end
            end
            S_SCAN2: begin
                if (tok_last.valid) begin
                    hold_bid_next   = tok_last.best_bid;
                    hold_ask_next   = tok_last.best_ask;
                    hold_bpres_next = tok_last.bid_have;
                    hold_apres_next = tok_last.ask_have;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_bid_next    = hold_bid_reg;
                    m_ask_next    = hold_ask_reg;
                    m_bpres_next  = hold_bpres_reg;
                    m_apres_next  = hold_apres_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            launch_reg.valid <= 1'b0;
            ctr_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            ctr_reg     <= ctr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        is_ask_reg     <= is_ask_next;
        price_reg      <= price_next;
        id_reg         <= id_next;
        status_reg     <= status_next;
        hold_bid_reg   <= hold_bid_next;
        hold_ask_reg   <= hold_ask_next;
        hold_bpres_reg <= hold_bpres_next;
        hold_apres_reg <= hold_apres_next;
        m_status_reg   <= m_status_next;
        m_bid_reg      <= m_bid_next;
        m_ask_reg      <= m_ask_next;
        m_bpres_reg    <= m_bpres_next;
        m_apres_reg    <= m_apres_next;
    end

    assign launch   = launch_reg;
    assign arrival  = ctr_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'd0, m_apres_reg, m_ask_reg, m_bpres_reg, m_bid_reg};

`ifndef SYNTHESIS
    // a token only reaches the row end while a scan is pending
    a_tok_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.valid |-> (state_reg == S_SCAN1 || state_reg == S_SCAN2))
        else $error("scan token arrived outside a scan");

    // arrival counter only ever steps by one
    a_ctr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (ctr_reg == $past(ctr_reg) || ctr_reg == $past(ctr_reg) + 32'd1))
        else $error("arrival counter jumped");

    // an empty side reports a zero price
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_bpres_reg || m_bid_reg == 32'd0) &&
                         (m_apres_reg || m_ask_reg == 32'd0)))
        else $error("empty side with nonzero price");

    // a slot write only comes out of the commit step
    a_wr_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.set || wr.clr) |-> (state_reg == S_SCAN1 && tok_last.valid && !(wr.set && wr.clr)))
        else $error("slot write outside commit");
`endif

endmodule

// File: hw/rtl/limit_order_book_best_price_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_best_price_core: bounded order book with top of book
// Row of order slots scanned by a travelling token, plus a sequencer.
// ----------------------------------------------------------------------------
// Each order message (add or cancel) gives one result: a status and the best
// bid and best ask with present flags. The book holds ENTRIES orders, one per
// cell of a row; a token walks the row one cell per cycle. An item costs two
// walks (search, then top of book after the commit); an add with an unknown
// side needs only the top-of-book walk. The next item is accepted only once
// the result of the last one has moved into the output register.
// A finished result waits in an output register and does not block the next
// input transfer.
module limit_order_book_best_price_core
    import lobbp_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // order_id[31:0], side[39:32], price[71:40]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // best_bid[31:0], bid_present[32],
                                   // best_ask[64:33], ask_present[65], zero pad
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    lobbp_tok_t       launch;
    lobbp_wr_t        wr;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      arrival;

    lobbp_tok_t       tok      [ENTRIES];
    logic [IDX_W-1:0] bid_idx  [ENTRIES];
    logic [IDX_W-1:0] ask_idx  [ENTRIES];
    logic [IDX_W-1:0] free_idx [ENTRIES];

    // Sequencer
    lobbp_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .launch        (launch),
        .tok_last      (tok[ENTRIES-1]),
        .bid_idx_last  (bid_idx[ENTRIES-1]),
        .ask_idx_last  (ask_idx[ENTRIES-1]),
        .free_idx_last (free_idx[ENTRIES-1]),
        .wr            (wr),
        .wr_idx        (wr_idx),
        .arrival       (arrival)
    );

    // Slot row
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        if (k == 0) begin : g_head
            lobbp_cell #(
                .IDX_W (IDX_W),
                .IDX   (k)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .tok_in       (launch),
                .bid_idx_in   ({IDX_W{1'b0}}),
                .ask_idx_in   ({IDX_W{1'b0}}),
                .free_idx_in  ({IDX_W{1'b0}}),
                .wr           (wr),
                .wr_idx       (wr_idx),
                .arrival      (arrival),
                .tok_out      (tok[k]),
                .bid_idx_out  (bid_idx[k]),
                .ask_idx_out  (ask_idx[k]),
                .free_idx_out (free_idx[k])
            );
        end else begin : g_body
            lobbp_cell #(
                .IDX_W (IDX_W),
                .IDX   (k)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .tok_in       (tok[k-1]),
                .bid_idx_in   (bid_idx[k-1]),
                .ask_idx_in   (ask_idx[k-1]),
                .free_idx_in  (free_idx[k-1]),
                .wr           (wr),
                .wr_idx       (wr_idx),
                .arrival      (arrival),
                .tok_out      (tok[k]),
                .bid_idx_out  (bid_idx[k]),
                .ask_idx_out  (ask_idx[k]),
                .free_idx_out (free_idx[k])
            );
        end
    end

endmodule

// File: test/top_of_book_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_of_book_checker: result checker for the best-price order book
// Watches both stream channels, keeps its own copy of the book, predicts the
// status and top of book for every input transfer and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module top_of_book_checker
    import lobbp_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // order_id[31:0], side[39:32], price[71:40]
    input  logic [0:0]  s_tuser,   // func[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // best_bid[31:0], bid_present[32],
                                   // best_ask[64:33], ask_present[65], zero pad
    input  logic [2:0]  m_tuser,   // status[2:0]
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [2:0]  status;
        logic [31:0] best_bid;
        logic        bid_present;
        logic [31:0] best_ask;
        logic        ask_present;
    } quote_t;

    // Shadow book
    logic        book_live  [ENTRIES];
    logic        book_ask   [ENTRIES];
    logic [31:0] book_price [ENTRIES];
    logic [31:0] book_id    [ENTRIES];
    logic [31:0] book_stamp [ENTRIES];
    logic [31:0] arrivals;

    quote_t quotes_due[$];
    int     mismatches = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Order to cancel on one side: lowest price, then oldest; -1 if none
    function automatic int find_order(input logic want_ask, input logic [31:0] id);
        int          pick;
        logic [31:0] pick_price;
        logic [31:0] pick_age;
        logic [31:0] age;
        pick       = -1;
        pick_price = '0;
        pick_age   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!book_live[i] || book_ask[i] != want_ask || book_id[i] != id)
                continue;
            age = arrivals - book_stamp[i];
            if (pick < 0 || book_price[i] < pick_price ||
                (book_price[i] == pick_price && age > pick_age)) begin
                pick       = i;
                pick_price = book_price[i];
                pick_age   = age;
            end
        end
        return pick;
    endfunction

    // Apply one order message to the shadow book and predict its result
    task automatic book_apply(input logic func, input logic [31:0] id,
                              input logic [7:0] side, input logic [31:0] price,
                              output quote_t q);
        int slot;
        q.best_bid    = '0;
        q.best_ask    = '0;
        q.bid_present = 1'b0;
        q.ask_present = 1'b0;
        if (func == FUNC_ADD) begin
            if (side != SIDE_BID && side != SIDE_ASK) begin
                q.status = ST_SIDE_IGNORED;
            end else begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!book_live[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    q.status = ST_FULL;
                end else begin
                    book_live[slot]  = 1'b1;
                    book_ask[slot]   = (side == SIDE_ASK);
                    book_price[slot] = price;
                    book_id[slot]    = id;
                    book_stamp[slot] = arrivals;
                    arrivals         = arrivals + 32'd1;
                    q.status         = ST_ADDED;
                end
            end
        end else begin
            // bids are searched before asks
            slot = find_order(1'b0, id);
            if (slot < 0) slot = find_order(1'b1, id);
            if (slot < 0) begin
                q.status = ST_NOT_FOUND;
            end else begin
                book_live[slot] = 1'b0;
                q.status        = ST_CANCELLED;
            end
        end
        // top of book after the update
        for (int i = 0; i < ENTRIES; i++) begin
            if (!book_live[i]) continue;
            if (book_ask[i]) begin
                if (!q.ask_present || book_price[i] < q.best_ask) q.best_ask = book_price[i];
                q.ask_present = 1'b1;
            end else begin
                if (!q.bid_present || book_price[i] > q.best_bid) q.best_bid = book_price[i];
                q.bid_present = 1'b1;
            end
        end
    endtask

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        quote_t q;
        quote_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) book_live[i] = 1'b0;
            arrivals = '0;
            quotes_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                book_apply(s_tuser[0], s_tdata[31:0], s_tdata[39:32], s_tdata[71:40], q);
                quotes_due.insert(quotes_due.size(), q);
            end
            if (m_tvalid && m_tready) begin
                if (quotes_due.size() == 0) begin
                    flag_mismatch("unexpected result status", {29'd0, m_tuser}, 32'd0);
                end else begin
                    want = quotes_due.pop_front();
                    if (m_tuser != want.status)
                        flag_mismatch("status", {29'd0, m_tuser}, {29'd0, want.status});
                    if (m_tdata[31:0] != want.best_bid)
                        flag_mismatch("best_bid", m_tdata[31:0], want.best_bid);
                    if (m_tdata[32] != want.bid_present)
                        flag_mismatch("bid_present", {31'd0, m_tdata[32]},
                                      {31'd0, want.bid_present});
                    if (m_tdata[64:33] != want.best_ask)
                        flag_mismatch("best_ask", m_tdata[64:33], want.best_ask);
                    if (m_tdata[65] != want.ask_present)
                        flag_mismatch("ask_present", {31'd0, m_tdata[65]},
                                      {31'd0, want.ask_present});
                end
            end
        end
        pending    <= quotes_due.size();
        fail_count <= mismatches;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for limit_order_book_best_price_core
// Sends a directed set of adds and cancels, then random order traffic in
// rounds that fill, churn and drain the book, under three idling mixes on the
// two channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import lobbp_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int ITEM_CYCLES = 2 * ENTRIES + 4;
    localparam int HOLD_CYCLES = 800;
    localparam int QUIET_LIMIT = HOLD_CYCLES + 20 * ITEM_CYCLES;
    localparam int ROUND_ITEMS = 95;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count;
    int pending;
    int send_idle_pct = 23;
    int recv_idle_pct = 45;
    int hold_requests = 0;

    // Ids mostly come from a small pool so that cancels hit and ids repeat
    logic [31:0] id_pool [16] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                  32'h0000_0003, 32'h0000_0007, 32'h0000_0010,
                                  32'h0000_00ff, 32'h0001_0000, 32'h1234_5678,
                                  32'h5555_5555, 32'h7fff_ffff, 32'h8000_0000,
                                  32'haaaa_aaaa, 32'hdead_0001, 32'hffff_fffe,
                                  32'hffff_ffff};

    limit_order_book_best_price_core #(.ENTRIES(ENTRIES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    top_of_book_checker #(.ENTRIES(ENTRIES)) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb failed");
        $finish;
    end

    // One input transfer, with a random idle gap in front
    task automatic send_order(input logic func, input logic [31:0] id,
                              input logic [7:0] side, input logic [31:0] price);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {price, side, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Mostly a narrow band of prices so that levels repeat
    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h0000_0000;
        if (r < 10) return 32'hffff_ffff;
        if (r < 25) return $urandom;
        return 32'd1000 + $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] pick_side();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return SIDE_BID;
        if (r < 90) return SIDE_ASK;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int add_pct [6] = '{95, 50, 15, 95, 70, 30};
        logic func;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty book, unknown sides, extreme ids and prices
        send_order(FUNC_CANCEL, 32'h0000_0000, SIDE_BID, 32'd0);
        send_order(FUNC_ADD,    32'h0000_0001, 8'h00, 32'd10);
        send_order(FUNC_ADD,    32'h0000_0001, 8'hff, 32'd10);
        send_order(FUNC_ADD,    32'h8000_0000, SIDE_BID, 32'h0000_0000);
        send_order(FUNC_ADD,    32'h7fff_ffff, SIDE_ASK, 32'hffff_ffff);
        send_order(FUNC_ADD,    32'hffff_ffff, SIDE_BID, 32'hffff_ffff);
        send_order(FUNC_ADD,    32'h0000_0005, SIDE_ASK, 32'h0000_0000);
        // duplicate ids: cancel picks bids first, lowest price, then oldest
        send_order(FUNC_ADD,    32'h0000_0007, SIDE_BID, 32'd100);
        send_order(FUNC_ADD,    32'h0000_0007, SIDE_BID, 32'd100);
        send_order(FUNC_ADD,    32'h0000_0007, SIDE_BID, 32'd50);
        send_order(FUNC_ADD,    32'h0000_0007, SIDE_ASK, 32'd20);
        send_order(FUNC_CANCEL, 32'h0000_0007, 8'h00, 32'hffff_ffff);
        send_order(FUNC_CANCEL, 32'h0000_0007, SIDE_ASK, 32'd0);
        send_order(FUNC_CANCEL, 32'h0000_0007, SIDE_BID, 32'd0);
        send_order(FUNC_CANCEL, 32'h0000_0007, SIDE_BID, 32'd0);
        send_order(FUNC_CANCEL, 32'h0000_0007, SIDE_BID, 32'd0);
        // drain the extremes one by one
        send_order(FUNC_CANCEL, 32'hffff_ffff, SIDE_ASK, 32'd0);
        send_order(FUNC_CANCEL, 32'h8000_0000, SIDE_ASK, 32'd0);
        send_order(FUNC_CANCEL, 32'h7fff_ffff, SIDE_BID, 32'd0);
        send_order(FUNC_CANCEL, 32'h0000_0005, SIDE_BID, 32'd0);
        send_order(FUNC_CANCEL, 32'h0000_0005, SIDE_BID, 32'd0);

        // Random: three idling mixes, rounds that fill, churn and drain
        for (int mode = 0; mode < 3; mode++) begin
            wait_drained();
            case (mode)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct <= 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct <= 23;
                    // long receiver hold-off while the sender keeps offering
                    hold_requests <= hold_requests + 1;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int round = 0; round < 6; round++) begin
                for (int n = 0; n < ROUND_ITEMS; n++) begin
                    func = ($urandom_range(0, 99) < add_pct[round]) ? FUNC_ADD : FUNC_CANCEL;
                    send_order(func, pick_id(), pick_side(), pick_price());
                end
            end
        end

        // Wait for the last results, then a short tail
        wait_drained();
        repeat (ITEM_CYCLES + 4) @(posedge aclk);
        if (fail_count == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

endmodule
